### rtl/tmsa_pkg.sv
package tmsa_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int CFG_FLOOR   = 3;

	localparam int SAMPLE_W = 16;
	localparam int CNT_W    = 7;
	localparam int SUM_W    = 22;
	localparam int TRIM_W   = SUM_W + 1;
	localparam int QUO_W    = SUM_W;
	localparam int DIV_W    = 6;
	localparam int STEP_W   = $clog2(QUO_W);
	localparam int MEAN_W   = 16;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_COUNT  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_MIN_VALID     = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_DISCARD_FIRST = 2'd2;

	localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = 7'd16;
	localparam logic [CNT_W-1:0] MIN_VALID_RST    = 7'd6;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

	// One finished window, handed from the accumulator to the divider
	typedef struct packed {
		logic                       pub;
		logic signed [SUM_W-1:0]    sum;
		logic signed [SAMPLE_W-1:0] vmin;
		logic signed [SAMPLE_W-1:0] vmax;
		logic [CNT_W-1:0]           good;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_TRIM,
		BK_DIV,
		BK_DONE
	} back_state_t;

	function automatic logic [CNT_W-1:0] clamp_cfg(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v < CNT_W'(CFG_FLOOR))
			r = CNT_W'(CFG_FLOOR);
		else if (v > CNT_W'(MAX_SAMPLES))
			r = CNT_W'(MAX_SAMPLES);
		else
			r = v;
		return r;
	endfunction

endpackage

### rtl/tmsa_front.sv
module tmsa_front import tmsa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SAMPLE_W-1:0]   in_sample,
	input  logic                  in_ok,
	output logic                  push,
	output job_t                  push_job,
	input  logic                  queue_full
);

	logic [CNT_W-1:0] sample_count_q;
	logic [CNT_W-1:0] min_valid_q;
	logic             discard_first_q;

	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SAMPLE_W-1:0] min_q;
	logic signed [SAMPLE_W-1:0] max_q;
	logic [CNT_W-1:0]           good_q;
	logic [CNT_W-1:0]           pos_q;

	logic signed [SAMPLE_W-1:0] v;
	logic                       settle;
	logic                       take;
	logic                       last;
	logic                       accept;
	logic [CNT_W:0]             length;
	logic signed [SUM_W-1:0]    sum_nx;
	logic signed [SAMPLE_W-1:0] min_nx;
	logic signed [SAMPLE_W-1:0] max_nx;
	logic [CNT_W-1:0]           good_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q  <= SAMPLE_COUNT_RST;
			min_valid_q     <= MIN_VALID_RST;
			discard_first_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_SAMPLE_COUNT:  sample_count_q  <= cfg_data;
				CFG_MIN_VALID:     min_valid_q     <= cfg_data;
				CFG_DISCARD_FIRST: discard_first_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		v       = $signed(in_sample);
		settle  = discard_first_q && (pos_q == '0);
		take    = !settle && in_ok;
		length  = {1'b0, clamp_cfg(sample_count_q)} + (CNT_W+1)'(discard_first_q);
		last    = !(({1'b0, pos_q} + (CNT_W+1)'(1)) < length);
		sum_nx  = take ? sum_q + SUM_W'(v) : sum_q;
		min_nx  = (take && (v < min_q)) ? v : min_q;
		max_nx  = (take && (v > max_q)) ? v : max_q;
		good_nx = take ? good_q + CNT_W'(1) : good_q;

		push          = accept && last;
		push_job.pub  = good_nx >= clamp_cfg(min_valid_q);
		push_job.sum  = sum_nx;
		push_job.vmin = min_nx;
		push_job.vmax = max_nx;
		push_job.good = good_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			min_q  <= SAMPLE_MAX;
			max_q  <= SAMPLE_MIN;
			good_q <= '0;
			pos_q  <= '0;
		end else if (accept) begin
			if (last) begin
				sum_q  <= '0;
				min_q  <= SAMPLE_MAX;
				max_q  <= SAMPLE_MIN;
				good_q <= '0;
				pos_q  <= '0;
			end else begin
				sum_q  <= sum_nx;
				min_q  <= min_nx;
				max_q  <= max_nx;
				good_q <= good_nx;
				pos_q  <= pos_q + CNT_W'(1);
			end
		end
	end

endmodule

### rtl/tmsa_queue.sv
module tmsa_queue import tmsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t pop_job,
	output logic empty
);

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;

	assign full    = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign pop_job = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");

endmodule

### rtl/tmsa_back.sv
module tmsa_back import tmsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              queue_empty,
	input  job_t              pop_job,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_published,
	output logic [MEAN_W-1:0] out_mean,
	output logic [CNT_W-1:0]  out_good
);

	back_state_t state_q;
	back_state_t state_nx;

	job_t                     job_q;
	logic [QUO_W-1:0]         quo_q;
	logic [DIV_W-1:0]         rem_q;
	logic [DIV_W-1:0]         divisor_q;
	logic [STEP_W-1:0]        step_q;
	logic                     out_valid_q;
	logic                     out_pub_q;
	logic [MEAN_W-1:0]        out_mean_q;
	logic [CNT_W-1:0]         out_good_q;

	logic signed [TRIM_W-1:0] trim;
	logic                     skip;
	logic [DIV_W:0]           rshift;
	logic                     ge;
	logic [DIV_W:0]           rdiff;
	logic                     out_free;
	logic                     load_out;
	logic [MEAN_W-1:0]        mean_sat;

	always_comb begin
		trim = TRIM_W'(job_q.sum) - TRIM_W'(job_q.vmin) - TRIM_W'(job_q.vmax);
		skip = !job_q.pub || trim[TRIM_W-1] || (trim == '0);

		rshift = {rem_q, quo_q[QUO_W-1]};
		ge     = rshift >= {1'b0, divisor_q};
		rdiff  = rshift - {1'b0, divisor_q};

		mean_sat = (quo_q[QUO_W-1:MEAN_W] != '0) ? '1 : quo_q[MEAN_W-1:0];
		out_free = !out_valid_q || out_ready;
	end

	always_comb begin
		state_nx = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!queue_empty) begin
					pop      = 1'b1;
					state_nx = BK_TRIM;
				end
			end
			BK_TRIM: state_nx = skip ? BK_DONE : BK_DIV;
			BK_DIV: begin
				if (step_q == STEP_W'(QUO_W - 1))
					state_nx = BK_DONE;
			end
			BK_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_nx;
	end

	// Restoring divide, one quotient bit per cycle; the dividend shifts out of quo_q
	always_ff @(posedge clk) begin
		if (pop)
			job_q <= pop_job;
		case (state_q)
			BK_TRIM: begin
				quo_q     <= skip ? '0 : trim[QUO_W-1:0];
				rem_q     <= '0;
				step_q    <= '0;
				divisor_q <= DIV_W'(job_q.good - CNT_W'(2));
			end
			BK_DIV: begin
				quo_q  <= {quo_q[QUO_W-2:0], ge};
				rem_q  <= ge ? rdiff[DIV_W-1:0] : rshift[DIV_W-1:0];
				step_q <= step_q + STEP_W'(1);
			end
			default: ;
		endcase
		if (load_out) begin
			out_pub_q  <= job_q.pub;
			out_mean_q <= mean_sat;
			out_good_q <= job_q.good;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid     = out_valid_q;
	assign out_published = out_pub_q;
	assign out_mean      = out_mean_q;
	assign out_good      = out_good_q;

	a_unpub_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_published) |-> (out_mean == '0))
		else $error("unpublished result carries a nonzero mean");

	a_pub_enough: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_published) |-> (out_good >= CNT_W'(CFG_FLOOR)))
		else $error("published result with fewer than three good samples");

endmodule

### rtl/trimmed_mean_sample_averager.sv
// Trimmed-mean sample averager.
// Input stream: s_axis_tdata carries one signed 16-bit conversion, s_axis_tuser
// its success flag. Each window is an optional settle conversion (dropped) and
// sample_count averaged conversions. The last conversion of a window produces
// one transaction on the output stream: m_axis_tuser is the published flag,
// m_axis_tdata holds the trimmed mean (sum - min - max) / (good - 2) clamped to
// 0..65535, and the good-sample count.
// Configuration: write cfg_data to register cfg_addr (0 sample_count,
// 1 min_valid, 2 discard_first) with cfg_we high; write only while idle.
// Throughput: the accumulator takes one conversion per cycle while the queue
// is not full. Each window end passes the bit-serial divider through load,
// trim, 22 quotient steps and output; a two-entry queue sits in between.
// Result path: once free, the divider pops the window from the queue, trims,
// divides and loads the output register, raising m_axis_tvalid; the divide is
// skipped when the window is not published or its trimmed sum is not positive.
// Stall: a held result stays in the output register; the divider then waits,
// the queue fills and s_axis_tready drops only when the queue is full.
// Reset (arst_n low) restores register defaults 16 / 6 / 1 and starts a new
// window with an empty queue and no pending result.
module trimmed_mean_sample_averager import tmsa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [15:0]           s_axis_tdata,   // [15:0] sample
	input  logic                  s_axis_tuser,   // [0] sample_ok
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [23:0]           m_axis_tdata,   // [15:0] mean_raw, [22:16] good_count, [23] 0
	output logic                  m_axis_tuser    // [0] published
);

	logic              push;
	job_t              push_job;
	logic              queue_full;
	logic              pop;
	job_t              pop_job;
	logic              queue_empty;
	logic [MEAN_W-1:0] mean;
	logic [CNT_W-1:0]  good;

	tmsa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_sample  (s_axis_tdata),
		.in_ok      (s_axis_tuser),
		.push       (push),
		.push_job   (push_job),
		.queue_full (queue_full)
	);

	tmsa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (queue_empty)
	);

	tmsa_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.queue_empty   (queue_empty),
		.pop_job       (pop_job),
		.pop           (pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_published (m_axis_tuser),
		.out_mean      (mean),
		.out_good      (good)
	);

	assign m_axis_tdata = {1'b0, good, mean};

endmodule
